@@ rtl/vucrp_pkg.sv @@
// ----------------------------------------------------------------------------
// vucrp_pkg
// Types and constants shared by the video unit processor register port.
// ----------------------------------------------------------------------------
package vucrp_pkg;

  localparam int unsigned OAM_BYTES = 256;
  localparam int unsigned OAM_AW    = $clog2(OAM_BYTES);

  localparam logic [14:0] ADDR_INC_ROW  = 15'h0020;
  localparam logic [14:0] ADDR_INC_COL  = 15'h0001;
  localparam logic [5:0]  PALETTE_PAGE  = 6'h3F;

  typedef enum logic [1:0] {
    CMD_WRITE      = 2'd0,
    CMD_READ       = 2'd1,
    CMD_MEM_RETURN = 2'd2,
    CMD_EVENT      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_PTR  = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDRESS  = 3'd6,
    REG_DATA     = 3'd7
  } reg_t;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_READ_DATA = 2'd1,
    KIND_MEM_WRITE = 2'd2,
    KIND_MEM_READ  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] mem_data;
    logic [3:0] event_flags;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  access_kind;
    logic [13:0] mem_address;
    logic [7:0]  data_out;
    logic [14:0] current_address;
    logic [14:0] temp_address;
    logic [2:0]  fine_x_out;
    logic [7:0]  ctrl_out;
    logic [7:0]  mask_out;
    logic        nmi_request;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [OAM_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [OAM_AW-1:0] raddr;
  } oam_req_t;

endpackage

@@ rtl/video_unit_cpu_register_port.sv @@
// ----------------------------------------------------------------------------
// video_unit_cpu_register_port
// Processor register port of a tile video unit with loopy scroll registers.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------
//   in_      | input     | in_valid/in_stall  | in_item  (in_item_t)
//   out_     | output    | out_valid/out_stall| out_item (out_item_t)
//
// One item per cycle sustained while out_stall is low; from acceptance to
// result an item passes the input register, then the result register.
// The sprite memory read port is pre-addressed with the next pointer, so an
// attribute read completes in the same single pass.
// Synchronous active-low reset clears all control and scroll state.
// in_stall rises only while a result is held and out_stall is high.
// ----------------------------------------------------------------------------
module video_unit_cpu_register_port (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vucrp_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vucrp_pkg::out_item_t out_item
);
  import vucrp_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      proc_go;
  logic      out_free;
  oam_req_t  oam_req;
  logic [7:0] oam_rd_data;
  out_item_t result;

  assign out_free = !out_valid_r || !out_stall;
  assign proc_go  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= proc_go;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go) begin
      out_item_r <= result;
    end
  end

  vucrp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (proc_go),
    .item        (in_item_r),
    .oam_rd_data (oam_rd_data),
    .oam_req     (oam_req),
    .result      (result)
  );

  vucrp_oam_ram #(
    .DEPTH (OAM_BYTES)
  ) u_oam_ram (
    .clk   (clk),
    .we    (oam_req.we),
    .waddr (oam_req.waddr),
    .wdata (oam_req.wdata),
    .raddr (oam_req.raddr),
    .rdata (oam_rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !proc_go) |=> !out_valid)
    else $error("result repeated after delivery");

  a_nmi_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.nmi_request) |-> (out_item.access_kind == KIND_NONE))
    else $error("interrupt request alongside an access");

  a_addr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.access_kind == KIND_NONE ||
                   out_item.access_kind == KIND_READ_DATA))
    |-> (out_item.mem_address == '0))
    else $error("memory address set without memory access");
`endif

endmodule

@@ rtl/vucrp_oam_ram.sv @@
// ----------------------------------------------------------------------------
// vucrp_oam_ram
// Sprite attribute memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vucrp_oam_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first on address collision
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/vucrp_core.sv @@
// ----------------------------------------------------------------------------
// vucrp_core
// Register state and single-pass update for one item.
// ----------------------------------------------------------------------------
module vucrp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  vucrp_pkg::in_item_t item,
  input  logic [7:0]          oam_rd_data,
  output vucrp_pkg::oam_req_t oam_req,
  output vucrp_pkg::out_item_t result
);
  import vucrp_pkg::*;

  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic [14:0]       cur_r, cur_nxt;
  logic [14:0]       tmp_r, tmp_nxt;
  logic [2:0]        fine_x_r, fine_x_nxt;
  logic              toggle_r, toggle_nxt;
  logic [OAM_AW-1:0] oam_ptr_r, oam_ptr_nxt;
  logic [7:0]        rbuf_r, rbuf_nxt;
  logic [7:0]        latch_r, latch_nxt;
  logic [4:0]        last_r, last_nxt;
  logic              vbl_r, vbl_nxt;
  logic              ovf_r, ovf_nxt;
  logic              hit_r, hit_nxt;
  logic              pal_r, pal_nxt;

  logic [14:0] inc;
  logic [7:0]  status;
  kind_t       kind;
  logic [13:0] addr;
  logic [7:0]  data;
  logic        nmi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r    <= '0;
      mask_r    <= '0;
      cur_r     <= '0;
      tmp_r     <= '0;
      fine_x_r  <= '0;
      toggle_r  <= 1'b0;
      oam_ptr_r <= '0;
      rbuf_r    <= '0;
      latch_r   <= '0;
      last_r    <= '0;
      vbl_r     <= 1'b0;
      ovf_r     <= 1'b0;
      hit_r     <= 1'b0;
      pal_r     <= 1'b0;
    end else if (go) begin
      ctrl_r    <= ctrl_nxt;
      mask_r    <= mask_nxt;
      cur_r     <= cur_nxt;
      tmp_r     <= tmp_nxt;
      fine_x_r  <= fine_x_nxt;
      toggle_r  <= toggle_nxt;
      oam_ptr_r <= oam_ptr_nxt;
      rbuf_r    <= rbuf_nxt;
      latch_r   <= latch_nxt;
      last_r    <= last_nxt;
      vbl_r     <= vbl_nxt;
      ovf_r     <= ovf_nxt;
      hit_r     <= hit_nxt;
      pal_r     <= pal_nxt;
    end
  end

  assign inc    = ctrl_r[2] ? ADDR_INC_ROW : ADDR_INC_COL;
  assign status = {vbl_r, hit_r, ovf_r, last_r};

  always_comb begin
    ctrl_nxt    = ctrl_r;
    mask_nxt    = mask_r;
    cur_nxt     = cur_r;
    tmp_nxt     = tmp_r;
    fine_x_nxt  = fine_x_r;
    toggle_nxt  = toggle_r;
    oam_ptr_nxt = oam_ptr_r;
    rbuf_nxt    = rbuf_r;
    latch_nxt   = latch_r;
    last_nxt    = last_r;
    vbl_nxt     = vbl_r;
    ovf_nxt     = ovf_r;
    hit_nxt     = hit_r;
    pal_nxt     = pal_r;
    kind        = KIND_NONE;
    addr        = '0;
    data        = '0;
    nmi         = 1'b0;
    oam_req.we    = 1'b0;
    oam_req.waddr = oam_ptr_r;
    oam_req.wdata = item.write_data;

    case (item.command)
      CMD_WRITE: begin
        latch_nxt = item.write_data;
        if (item.reg_index != REG_STATUS) begin
          last_nxt = item.write_data[4:0];
        end
        case (item.reg_index)
          REG_CTRL: begin
            ctrl_nxt         = item.write_data;
            tmp_nxt[11:10]   = item.write_data[1:0];
          end
          REG_MASK: begin
            mask_nxt = item.write_data;
          end
          REG_OAM_PTR: begin
            oam_ptr_nxt = item.write_data[OAM_AW-1:0];
          end
          REG_OAM_DATA: begin
            oam_req.we  = go;
            oam_ptr_nxt = oam_ptr_r + 1'b1;
          end
          REG_SCROLL: begin
            if (toggle_r) begin
              tmp_nxt[14:12] = item.write_data[2:0];
              tmp_nxt[9:5]   = item.write_data[7:3];
              toggle_nxt     = 1'b0;
            end else begin
              fine_x_nxt   = item.write_data[2:0];
              tmp_nxt[4:0] = item.write_data[7:3];
              toggle_nxt   = 1'b1;
            end
          end
          REG_ADDRESS: begin
            if (toggle_r) begin
              tmp_nxt[7:0] = item.write_data;
              cur_nxt      = tmp_nxt;
              toggle_nxt   = 1'b0;
            end else begin
              tmp_nxt[14]   = 1'b0;
              tmp_nxt[13:8] = item.write_data[5:0];
              toggle_nxt    = 1'b1;
            end
          end
          REG_DATA: begin
            kind    = KIND_MEM_WRITE;
            addr    = cur_r[13:0];
            data    = item.write_data;
            cur_nxt = {1'b0, cur_r[13:0]} + inc;
          end
          default: begin
          end
        endcase
      end
      CMD_READ: begin
        case (item.reg_index)
          REG_STATUS: begin
            vbl_nxt    = 1'b0;
            toggle_nxt = 1'b0;
            latch_nxt  = status;
            kind       = KIND_READ_DATA;
            data       = status;
          end
          REG_OAM_DATA: begin
            latch_nxt = oam_rd_data;
            kind      = KIND_READ_DATA;
            data      = oam_rd_data;
          end
          REG_DATA: begin
            kind    = KIND_MEM_READ;
            addr    = cur_r[13:0];
            cur_nxt = cur_r + inc;
            if (cur_r[13:8] == PALETTE_PAGE) begin
              pal_nxt = 1'b1;
            end else begin
              latch_nxt = rbuf_r;
              data      = rbuf_r;
            end
          end
          default: begin
            kind = KIND_READ_DATA;
            data = latch_r;
          end
        endcase
      end
      CMD_MEM_RETURN: begin
        rbuf_nxt = item.mem_data;
        if (pal_r) begin
          pal_nxt   = 1'b0;
          latch_nxt = item.mem_data;
          kind      = KIND_READ_DATA;
          data      = item.mem_data;
        end
      end
      default: begin
        if (item.event_flags[1]) begin
          vbl_nxt = 1'b0;
          ovf_nxt = 1'b0;
          hit_nxt = 1'b0;
        end
        if (item.event_flags[0]) begin
          vbl_nxt = 1'b1;
          nmi     = ctrl_r[7];
        end
        if (item.event_flags[2]) begin
          ovf_nxt = 1'b1;
        end
        if (item.event_flags[3]) begin
          hit_nxt = 1'b1;
        end
      end
    endcase

    // read port follows the pointer the next item will see
    oam_req.raddr = go ? oam_ptr_nxt : oam_ptr_r;
  end

  always_comb begin
    result.access_kind     = kind;
    result.mem_address     = addr;
    result.data_out        = data;
    result.current_address = cur_nxt;
    result.temp_address    = tmp_nxt;
    result.fine_x_out      = fine_x_nxt;
    result.ctrl_out        = ctrl_nxt;
    result.mask_out        = mask_nxt;
    result.nmi_request     = nmi;
  end

endmodule

@@ tb/vucrp_access_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vucrp_access_checker
// Watches both channels of the video unit register port, predicts each
// result from the accepted items and compares the results field by field.
// ----------------------------------------------------------------------------
module vucrp_access_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  vucrp_pkg::in_item_t  in_item,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  vucrp_pkg::out_item_t out_item,
  output int                   fail_count,
  output int                   pending
);
  import vucrp_pkg::*;

  logic [7:0]  ctrl_byte;
  logic [7:0]  mask_byte;
  logic [14:0] vaddr;
  logic [14:0] temp_addr;
  logic [2:0]  fine_scroll;
  logic        second_write;
  logic [7:0]  oam_ptr;
  logic [7:0]  oam_mem [OAM_BYTES];
  logic [7:0]  read_buf;
  logic [7:0]  open_bus;
  logic [4:0]  low_status;
  logic        vblank;
  logic        spr_ovf;
  logic        spr_hit;
  logic        palette_wait;

  out_item_t   expected_results [$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic out_item_t predict_access(input in_item_t it);
    out_item_t  r;
    logic [7:0] wd;
    logic [7:0] st;
    wd = it.write_data;
    r  = '0;
    case (cmd_t'(it.command))
      CMD_WRITE: begin
        open_bus = wd;
        if (reg_t'(it.reg_index) != REG_STATUS) low_status = wd[4:0];
        case (reg_t'(it.reg_index))
          REG_CTRL: begin
            ctrl_byte = wd;
            temp_addr[11:10] = wd[1:0];
          end
          REG_MASK: mask_byte = wd;
          REG_OAM_PTR: oam_ptr = wd;
          REG_OAM_DATA: begin
            oam_mem[oam_ptr] = wd;
            oam_ptr = oam_ptr + 8'd1;
          end
          REG_SCROLL: begin
            if (second_write) begin
              temp_addr[14:12] = wd[2:0];
              temp_addr[9:5]   = wd[7:3];
            end else begin
              fine_scroll    = wd[2:0];
              temp_addr[4:0] = wd[7:3];
            end
            second_write = !second_write;
          end
          REG_ADDRESS: begin
            if (second_write) begin
              temp_addr[7:0] = wd;
              vaddr = temp_addr;
            end else begin
              temp_addr[14:8] = {1'b0, wd[5:0]};
            end
            second_write = !second_write;
          end
          REG_DATA: begin
            vaddr[14] = 1'b0;
            r.access_kind = KIND_MEM_WRITE;
            r.mem_address = vaddr[13:0];
            r.data_out    = wd;
            vaddr = vaddr + (ctrl_byte[2] ? ADDR_INC_ROW : ADDR_INC_COL);
          end
          default: ;
        endcase
      end
      CMD_READ: begin
        case (reg_t'(it.reg_index))
          REG_STATUS: begin
            st = {vblank, spr_hit, spr_ovf, low_status};
            vblank       = 1'b0;
            second_write = 1'b0;
            open_bus     = st;
            r.access_kind = KIND_READ_DATA;
            r.data_out    = st;
          end
          REG_OAM_DATA: begin
            open_bus = oam_mem[oam_ptr];
            r.access_kind = KIND_READ_DATA;
            r.data_out    = open_bus;
          end
          REG_DATA: begin
            r.access_kind = KIND_MEM_READ;
            r.mem_address = vaddr[13:0];
            if (vaddr[13:8] == PALETTE_PAGE) begin
              palette_wait = 1'b1;
            end else begin
              open_bus   = read_buf;
              r.data_out = read_buf;
            end
            vaddr = vaddr + (ctrl_byte[2] ? ADDR_INC_ROW : ADDR_INC_COL);
          end
          default: begin
            r.access_kind = KIND_READ_DATA;
            r.data_out    = open_bus;
          end
        endcase
      end
      CMD_MEM_RETURN: begin
        read_buf = it.mem_data;
        if (palette_wait) begin
          palette_wait  = 1'b0;
          open_bus      = it.mem_data;
          r.access_kind = KIND_READ_DATA;
          r.data_out    = it.mem_data;
        end
      end
      default: begin
        if (it.event_flags[1]) begin
          vblank  = 1'b0;
          spr_ovf = 1'b0;
          spr_hit = 1'b0;
        end
        if (it.event_flags[0]) begin
          vblank = 1'b1;
          r.nmi_request = ctrl_byte[7];
        end
        if (it.event_flags[2]) spr_ovf = 1'b1;
        if (it.event_flags[3]) spr_hit = 1'b1;
      end
    endcase
    r.current_address = vaddr;
    r.temp_address    = temp_addr;
    r.fine_x_out      = fine_scroll;
    r.ctrl_out        = ctrl_byte;
    r.mask_out        = mask_byte;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      ctrl_byte    = '0;
      mask_byte    = '0;
      vaddr        = '0;
      temp_addr    = '0;
      fine_scroll  = '0;
      second_write = 1'b0;
      oam_ptr      = '0;
      read_buf     = '0;
      open_bus     = '0;
      low_status   = '0;
      vblank       = 1'b0;
      spr_ovf      = 1'b0;
      spr_hit      = 1'b0;
      palette_wait = 1'b0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(predict_access(in_item));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result item with no item outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("access_kind", want.access_kind, out_item.access_kind);
          check_field("mem_address", want.mem_address, out_item.mem_address);
          check_field("data_out", want.data_out, out_item.data_out);
          check_field("current_address", want.current_address, out_item.current_address);
          check_field("temp_address", want.temp_address, out_item.temp_address);
          check_field("fine_x_out", want.fine_x_out, out_item.fine_x_out);
          check_field("ctrl_out", want.ctrl_out, out_item.ctrl_out);
          check_field("mask_out", want.mask_out, out_item.mask_out);
          check_field("nmi_request", want.nmi_request, out_item.nmi_request);
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

@@ tb/video_unit_cpu_register_port_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_unit_cpu_register_port_test
// Drives register writes and reads, memory read returns and flag events into
// the register port: a directed opening, then address, scroll, sprite and
// flag sequences with random content mixed with noise, under three idle and
// stall profiles. The checker beside the block judges every result item.
// ----------------------------------------------------------------------------
module video_unit_cpu_register_port_test;
  import vucrp_pkg::*;

  localparam int TOTAL_ITEMS = 1000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          items_sent = 0;
  logic [7:0]  oam_ptr_shadow = '0;
  logic        oam_written [OAM_BYTES];

  video_unit_cpu_register_port dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  vucrp_access_checker access_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #1_000_000;
    $display("video_unit_cpu_register_port_test failed");
    $finish;
  end

  // never reads a sprite entry that has not been written
  task automatic drive_item(input in_item_t item);
    in_item_t it;
    it = item;
    if (it.command == CMD_READ && it.reg_index == REG_OAM_DATA
        && !oam_written[oam_ptr_shadow])
      it.reg_index = REG_STATUS;
    if (it.command == CMD_WRITE && it.reg_index == REG_OAM_PTR)
      oam_ptr_shadow = it.write_data;
    if (it.command == CMD_WRITE && it.reg_index == REG_OAM_DATA) begin
      oam_written[oam_ptr_shadow] = 1'b1;
      oam_ptr_shadow = oam_ptr_shadow + 8'd1;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_op(input cmd_t c, input reg_t r, input logic [7:0] value);
    logic [31:0] noise;
    in_item_t    it;
    noise = $urandom;
    it = noise[$bits(in_item_t)-1:0];
    it.command   = c;
    it.reg_index = r;
    case (c)
      CMD_WRITE:      it.write_data  = value;
      CMD_MEM_RETURN: it.mem_data    = value;
      CMD_EVENT:      it.event_flags = value[3:0];
      default: ;
    endcase
    drive_item(it);
  endtask

  task automatic random_burst();
    int          pick;
    logic [7:0]  hi;
    logic [31:0] noise;
    pick = $urandom_range(99);
    if (pick < 35) begin
      if ($urandom_range(3) == 0) send_op(CMD_WRITE, REG_CTRL, 8'($urandom));
      send_op(CMD_READ, REG_STATUS, 8'h00);
      hi = ($urandom_range(2) == 0) ? {2'($urandom), PALETTE_PAGE} : 8'($urandom);
      send_op(CMD_WRITE, REG_ADDRESS, hi);
      send_op(CMD_WRITE, REG_ADDRESS, 8'($urandom));
      repeat ($urandom_range(6, 1)) begin
        if ($urandom_range(1) == 1) begin
          send_op(CMD_READ, REG_DATA, 8'h00);
          if ($urandom_range(3) != 0) send_op(CMD_MEM_RETURN, REG_DATA, 8'($urandom));
        end else begin
          send_op(CMD_WRITE, REG_DATA, 8'($urandom));
        end
      end
    end else if (pick < 50) begin
      send_op(CMD_READ, REG_STATUS, 8'h00);
      send_op(CMD_WRITE, REG_SCROLL, 8'($urandom));
      send_op(CMD_WRITE, REG_SCROLL, 8'($urandom));
      if ($urandom_range(2) == 0) begin
        send_op(CMD_WRITE, REG_SCROLL, 8'($urandom));
        send_op(CMD_WRITE, REG_ADDRESS, 8'($urandom));
        send_op(CMD_READ, REG_DATA, 8'h00);
        send_op(CMD_MEM_RETURN, REG_DATA, 8'($urandom));
      end
    end else if (pick < 65) begin
      hi = ($urandom_range(1) == 1) ? 8'($urandom_range(255, 250)) : 8'($urandom);
      send_op(CMD_WRITE, REG_OAM_PTR, hi);
      repeat ($urandom_range(8, 1)) send_op(CMD_WRITE, REG_OAM_DATA, 8'($urandom));
      send_op(CMD_WRITE, REG_OAM_PTR, hi + 8'($urandom_range(3)));
      repeat ($urandom_range(3, 1)) send_op(CMD_READ, REG_OAM_DATA, 8'h00);
    end else if (pick < 80) begin
      send_op(CMD_EVENT, REG_CTRL, 8'($urandom));
      if ($urandom_range(1) == 1) send_op(CMD_EVENT, REG_CTRL, 8'($urandom));
      send_op(CMD_READ, REG_STATUS, 8'h00);
      send_op(CMD_READ, reg_t'($urandom_range(7)), 8'h00);
    end else if (pick < 88) begin
      send_op(CMD_WRITE, REG_CTRL, 8'($urandom));
      send_op(CMD_WRITE, REG_MASK, 8'($urandom));
    end else begin
      repeat ($urandom_range(6, 1)) begin
        noise = $urandom;
        drive_item(noise[$bits(in_item_t)-1:0]);
      end
    end
  endtask

  initial begin
    foreach (oam_written[i]) oam_written[i] = 1'b0;
    send_idle_pct  = 34;
    recv_stall_pct = 46;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_op(CMD_EVENT, REG_CTRL, 8'h0F);
    send_op(CMD_READ, REG_STATUS, 8'h00);
    send_op(CMD_WRITE, REG_CTRL, 8'h87);
    send_op(CMD_EVENT, REG_CTRL, 8'h01);
    send_op(CMD_EVENT, REG_CTRL, 8'h02);
    send_op(CMD_WRITE, REG_MASK, 8'hFF);
    send_op(CMD_WRITE, REG_STATUS, 8'hAA);
    send_op(CMD_READ, REG_CTRL, 8'h00);
    // fine y and coarse bits all set, then a second address write: address 7FFF
    send_op(CMD_WRITE, REG_SCROLL, 8'hFF);
    send_op(CMD_WRITE, REG_SCROLL, 8'hFF);
    send_op(CMD_WRITE, REG_SCROLL, 8'hFF);
    send_op(CMD_WRITE, REG_ADDRESS, 8'hFF);
    send_op(CMD_READ, REG_DATA, 8'h00);
    send_op(CMD_MEM_RETURN, REG_DATA, 8'h5A);
    send_op(CMD_MEM_RETURN, REG_DATA, 8'hA5);
    send_op(CMD_WRITE, REG_DATA, 8'h00);
    send_op(CMD_WRITE, REG_CTRL, 8'h00);
    send_op(CMD_WRITE, REG_MASK, 8'h00);
    send_op(CMD_WRITE, REG_ADDRESS, 8'h00);
    send_op(CMD_WRITE, REG_ADDRESS, 8'h00);
    send_op(CMD_READ, REG_DATA, 8'h00);
    send_op(CMD_WRITE, REG_OAM_PTR, 8'hFF);
    send_op(CMD_WRITE, REG_OAM_DATA, 8'h12);
    send_op(CMD_WRITE, REG_OAM_PTR, 8'hFF);
    send_op(CMD_READ, REG_OAM_DATA, 8'h00);
    send_op(CMD_READ, REG_SCROLL, 8'h00);

    while (items_sent < TOTAL_ITEMS / 3) random_burst();
    send_idle_pct  = 46;
    recv_stall_pct = 34;
    while (items_sent < 2 * TOTAL_ITEMS / 3) random_burst();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (items_sent < TOTAL_ITEMS) random_burst();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("video_unit_cpu_register_port_test passed");
    end else begin
      $display("video_unit_cpu_register_port_test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/vucrp_pkg.sv
rtl/vucrp_oam_ram.sv
rtl/vucrp_core.sv
rtl/video_unit_cpu_register_port.sv
tb/vucrp_access_checker.sv
tb/video_unit_cpu_register_port_test.sv
